>>> src/strict_lis_length_stream_macros.svh
// Assertion macros for the LIS length block.
// All of them sample on clk and are disabled while arst_n is low.
`ifndef STRICT_LIS_LENGTH_STREAM_MACROS_SVH
`define STRICT_LIS_LENGTH_STREAM_MACROS_SVH

`ifndef SYNTH
`define SLL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sll assertion failed");
`define SLL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sll assertion failed");
`define SLL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sll assertion failed");
`else
`define SLL_ASSERT(lbl, prop)
`define SLL_ASSERT_IMP(lbl, ante, cons)
`define SLL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> src/sll_pkg.sv
package sll_pkg;

	localparam int MAX_LEN = 256;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 9;

	// what a cell tells its right-hand neighbour
	typedef struct packed {
		logic occ;
		logic ge;
	} sll_link_t;

endpackage

>>> src/sll_ifs.sv
interface sll_item_if import sll_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    start_req;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output start_req, output value, input ready);
	modport sink   (input valid, input start_req, input value, output ready);
endinterface

interface sll_result_if import sll_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] length;
	logic             overflow;

	modport source (output valid, output length, output overflow, input ready);
	modport sink   (input valid, input length, input overflow, output ready);
endinterface

>>> src/strict_lis_length_stream.sv
// Streaming length of the longest strictly increasing subsequence.
// Channel item (sink): start_req, signed 32-bit value. start_req clears the
// stored count and the overflow flag before its own value is taken.
// Channel result (source): 9-bit length and sticky overflow, one beat per item.
// The tails sit in a row of MAX_LEN cells; every cell compares the incoming
// value against its tail in the same cycle and checks its left neighbour to
// decide whether it is the one to replace or extend.
// The result beat is valid in the cycle after the item beat is accepted.
// Throughput: one item per cycle while the result register is empty or read,
// limited by the combinational compare row and the next item's count update.
// The result sits in an output register; a new item is taken while that
// register is empty or being read, so a stalled receiver holds off the input
// after one beat of slack.
// Reset (arst_n low) empties the store and clears the count, the overflow flag
// and the result valid flag. Tail registers are not reset; only occupied cells
// below the count are ever looked at.
`include "strict_lis_length_stream_macros.svh"

module strict_lis_length_stream import sll_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sll_item_if.sink     item,
	sll_result_if.source result
);

	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic                   res_valid_q;
	logic [LEN_W-1:0]       length_q;
	logic                   overflow_q;

	logic                   item_fire;
	logic [CNT_W-1:0]       count_eff;
	logic                   ovf_eff;
	logic [CNT_W-1:0]       count_nxt;
	logic                   ovf_nxt;
	logic                   ovf_set;
	logic                   inc;
	logic [LEN_W+CNT_W-1:0] len_wide;
	logic [MAX_LEN-1:0]     append_vec;
	sll_link_t              links [MAX_LEN+1];

	assign item.ready = !res_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;

	assign count_eff = item.start_req ? '0 : count_q;
	assign ovf_eff   = item.start_req ? 1'b0 : ovf_q;

	// left edge of the row looks like an occupied cell that is below any key
	assign links[0].occ = 1'b1;
	assign links[0].ge  = 1'b0;

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic occ;

		assign occ = count_eff > CNT_W'(k);

		sll_cell u_cell (
			.clk    (clk),
			.wr_en  (item_fire),
			.key    (item.value),
			.occ    (occ),
			.prev   (links[k]),
			.link   (links[k+1]),
			.append (append_vec[k])
		);
	end

	assign inc       = |append_vec;
	// full store and last tail below the key: extension dropped
	assign ovf_set   = (count_eff == CNT_W'(MAX_LEN)) && !links[MAX_LEN].ge;
	assign count_nxt = count_eff + CNT_W'(inc);
	assign ovf_nxt   = ovf_eff || ovf_set;
	assign len_wide  = {{LEN_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				count_q <= count_nxt;
				ovf_q   <= ovf_nxt;
			end
			if (item_fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			length_q   <= len_wide[LEN_W-1:0];
			overflow_q <= ovf_nxt;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.length   = length_q;
	assign result.overflow = overflow_q;

	`SLL_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_LEN))
	`SLL_ASSERT(a_one_append, $onehot0(append_vec))
	`SLL_ASSERT_IMP(a_ovf_full, ovf_q, count_q == CNT_W'(MAX_LEN))
	`SLL_ASSERT_NXT(a_fire_result, item_fire, res_valid_q)

endmodule

>>> src/sll_cell.sv
module sll_cell import sll_pkg::*; (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic signed [VAL_W-1:0] key,
	input  logic                    occ,
	input  sll_link_t               prev,
	output sll_link_t               link,
	output logic                    append
);

	logic signed [VAL_W-1:0] tail_q;
	logic                    ge;
	logic                    replace;

	// store is sorted, so "first tail >= key" only needs the left neighbour's flag
	assign ge      = occ && (tail_q >= key);
	assign replace = occ && (tail_q > key) && !prev.ge;
	assign append  = !occ && prev.occ && !prev.ge;

	assign link.occ = occ;
	assign link.ge  = ge;

	always_ff @(posedge clk) begin
		if (wr_en && (replace || append)) begin
			tail_q <= key;
		end
	end

endmodule
